[hw/rtl/assert_macros.svh]
// Assertion macros for the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/frtc_pkg.sv]
// Package with the request and result types and register map of the system timer.
`timescale 1ns / 1ps

package frtc_pkg;

    // Channel count limits; the status word has room for eight channels.
    localparam int DEFAULT_CHANNELS = 4;
    localparam int MAX_CHANNELS     = 8;
    localparam int FLAGS_W          = 4;
    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 64;

    // Request action codes; code three does nothing.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Word offsets of the register map.
    localparam logic [2:0] OFF_STATUS   = 3'd0;
    localparam logic [2:0] OFF_COUNT_LO = 3'd1;
    localparam logic [2:0] OFF_COUNT_HI = 3'd2;
    localparam int         OFF_COMPARE  = 3;

    typedef struct packed {
        logic [1:0]        action;
        logic [2:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [FLAGS_W-1:0] match_flags;
    } out_item_t;

endpackage

[hw/rtl/frtc_core.sv]
// Counter, compare registers and match status of the system timer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frtc_core #(
    parameter int CHANNELS = frtc_pkg::DEFAULT_CHANNELS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  frtc_pkg::in_item_t  item,
    output frtc_pkg::out_item_t result
);
    import frtc_pkg::*;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  count_inc;
    logic [DATA_W-1:0]   compare_reg  [CHANNELS];
    logic [DATA_W-1:0]   compare_next [CHANNELS];
    logic [CHANNELS-1:0] status_reg;
    logic [CHANNELS-1:0] status_next;
    logic [CHANNELS-1:0] hit;
    logic [CHANNELS-1:0] ch_sel;
    logic [DATA_W-1:0]   read_data;
    logic [MAX_CHANNELS-1:0] status_wide;
    logic                is_tick;
    logic                is_read;
    logic                is_write;

    assign is_tick  = (item.action == ACT_TICK);
    assign is_read  = (item.action == ACT_READ);
    assign is_write = (item.action == ACT_WRITE);
    assign count_inc = count_reg + COUNT_W'(1);

    // Channel decode and match against the incremented low word.
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            ch_sel[i] = (int'(item.reg_index) == OFF_COMPARE + i);
            hit[i]    = (compare_reg[i] == count_inc[DATA_W-1:0]);
        end
    end

    // Next state for the request being retired.
    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        for (int i = 0; i < CHANNELS; i++) begin
            compare_next[i] = compare_reg[i];
        end
        if (en) begin
            if (is_tick) begin
                count_next  = count_inc;
                status_next = status_reg | hit;
            end else if (is_write) begin
                if (item.reg_index == OFF_STATUS) begin
                    status_next = status_reg & ~item.write_data[CHANNELS-1:0];
                end
                for (int i = 0; i < CHANNELS; i++) begin
                    if (ch_sel[i]) begin
                        compare_next[i] = item.write_data;
                    end
                end
            end
        end
    end

    // Read multiplexer over the register map.
    always_comb begin
        read_data = '0;
        if (is_read) begin
            unique case (item.reg_index)
                OFF_STATUS:   read_data = DATA_W'(status_reg);
                OFF_COUNT_LO: read_data = count_reg[DATA_W-1:0];
                OFF_COUNT_HI: read_data = count_reg[COUNT_W-1:DATA_W];
                default: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (ch_sel[i]) begin
                            read_data = compare_reg[i];
                        end
                    end
                end
            endcase
        end
    end

    // Result: read data and the status after this request.
    assign status_wide        = MAX_CHANNELS'(status_next);
    assign result.read_data   = read_data;
    assign result.match_flags = status_wide[FLAGS_W-1:0];

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            status_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                compare_reg[i] <= '0;
            end
        end else begin
            count_reg  <= count_next;
            status_reg <= status_next;
            for (int i = 0; i < CHANNELS; i++) begin
                compare_reg[i] <= compare_next[i];
            end
        end
    end

    // A tick advances the counter by exactly one.
    `ASSERT_CLKD(a_tick_count, aclk, aresetn, (en && is_tick) |=> (count_reg == $past(count_inc)), "counter did not advance on tick")
    // Match bits only clear through a status write.
    `ASSERT_CLKD(a_status_sticky, aclk, aresetn, !(en && is_write && item.reg_index == OFF_STATUS) |=> (($past(status_reg) & ~status_reg) == '0), "match bit cleared without status write")
    // A write to the first compare offset lands in channel zero.
    `ASSERT_CLKD(a_cmp_write, aclk, aresetn, (en && is_write && ch_sel[0]) |=> (compare_reg[0] == $past(item.write_data)), "compare write lost")

endmodule

[hw/rtl/free_running_timer_with_compares.sv]
// Top level of the system timer: request register, timer core and result register.
// Usage:
//   Requests enter on s_valid/s_ready/s_data. Each request is a timebase tick,
//   a register read or a register write (word offsets: status, count low,
//   count high, then one compare register per channel).
//   Every request yields exactly one result on m_valid/m_ready/m_data, holding
//   the read data (zero for ticks and writes) and the match flags after it.
//   Each accepted request passes the request register, then the result
//   register, before m_valid. Throughput is one request per cycle while m_ready
//   is high, set by the combinational increment and compare path between them.
//   A request is taken while a finished result waits, as long as the request
//   register can move on; when the receiver stalls, both registers fill and
//   s_ready drops, and nothing is lost.
//   Synchronous reset (aresetn low) clears the counter, the compare registers,
//   the match status and both valid flags.
`timescale 1ns / 1ps

module free_running_timer_with_compares #(
    parameter int CHANNELS = frtc_pkg::DEFAULT_CHANNELS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  frtc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output frtc_pkg::out_item_t m_data
);
    import frtc_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_data_reg;
    out_item_t result;
    logic      advance;
    logic      accept;

    // Handshake: the request stage moves on when the result slot is free.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    frtc_core #(
        .CHANNELS(CHANNELS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (advance),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[tb/free_running_timer_with_compares_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the system timer: directed and random bus requests with checked results.

module free_running_timer_with_compares_tb;
    import frtc_pkg::*;

    localparam int CHANNELS        = DEFAULT_CHANNELS;
    localparam int RANDOM_REQUESTS = 700;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Timer state tracked request by request, plus the replies still owed by the block.
    class timer_scoreboard;
        bit [COUNT_W-1:0]  tick_count;
        bit [DATA_W-1:0]   compare_regs [CHANNELS];
        bit [CHANNELS-1:0] match_bits;
        out_item_t         pending_replies [$];
        int error_count;
        int checked;
        int ticks;
        int reads;
        int writes;
        int others;
        int match_events;

        // Advance the timer state for an accepted request and queue its reply.
        function void apply_request(in_item_t req);
            out_item_t reply;
            int chan;
            reply.read_data = '0;
            chan = int'(req.reg_index) - OFF_COMPARE;
            case (req.action)
                ACT_TICK: begin
                    ticks++;
                    tick_count = tick_count + 1;
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (compare_regs[i] == tick_count[DATA_W-1:0]) begin
                            if (!match_bits[i]) match_events++;
                            match_bits[i] = 1'b1;
                        end
                    end
                end
                ACT_READ: begin
                    reads++;
                    if (req.reg_index == OFF_STATUS) begin
                        reply.read_data = DATA_W'(match_bits);
                    end else if (req.reg_index == OFF_COUNT_LO) begin
                        reply.read_data = tick_count[DATA_W-1:0];
                    end else if (req.reg_index == OFF_COUNT_HI) begin
                        reply.read_data = tick_count[COUNT_W-1:DATA_W];
                    end else if (chan >= 0 && chan < CHANNELS) begin
                        reply.read_data = compare_regs[chan];
                    end
                end
                ACT_WRITE: begin
                    writes++;
                    // Status bits are write-one-to-clear; counter words are read-only.
                    if (req.reg_index == OFF_STATUS) begin
                        match_bits &= ~req.write_data[CHANNELS-1:0];
                    end else if (chan >= 0 && chan < CHANNELS) begin
                        compare_regs[chan] = req.write_data;
                    end
                end
                default: begin
                    others++;
                end
            endcase
            reply.match_flags = FLAGS_W'(match_bits);
            pending_replies.push_back(reply);
        endfunction

        // Compare one reply from the block with the oldest one owed.
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_replies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, read_data %h, match_flags %h",
                         $time, got.read_data, got.match_flags);
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                error_count++;
                $display("%0t: read_data expected %h, actual %h",
                         $time, want.read_data, got.read_data);
            end
            if (got.match_flags !== want.match_flags) begin
                error_count++;
                $display("%0t: match_flags expected %h, actual %h",
                         $time, want.match_flags, got.match_flags);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    timer_scoreboard sb;
    bit              no_idle;

    free_running_timer_with_compares uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock, 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

    function automatic in_item_t make_request(input logic [1:0] act, input logic [2:0] idx,
                                              input logic [DATA_W-1:0] data);
        in_item_t req;
        req.action     = act;
        req.reg_index  = idx;
        req.write_data = data;
        return req;
    endfunction

    // Present one request after a random gap and hold it until it is taken.
    // Called and returns just after a falling edge.
    task automatic send_request(input in_item_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.apply_request(req);
        @(negedge aclk);
    endtask

    // Result side: stall a random number of cycles, then take and check one result.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            sb.check_result(m_data);
        end
    end

    initial begin : stimulus
        int pick;
        int sel;
        int guard;
        logic [1:0]        act;
        logic [2:0]        idx;
        logic [DATA_W-1:0] data;

        sb      = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        no_idle = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every offset read from reset, the idle action, ignored writes.
        for (int off = 0; off < 8; off++) begin
            send_request(make_request(ACT_READ, 3'(off), 32'hFFFF_FFFF));
        end
        send_request(make_request(ACT_NONE, 3'd7, 32'hFFFF_FFFF));
        send_request(make_request(ACT_WRITE, OFF_COUNT_LO, 32'hFFFF_FFFF));
        send_request(make_request(ACT_WRITE, OFF_COUNT_HI, 32'hFFFF_FFFF));
        send_request(make_request(ACT_WRITE, 3'd7, 32'hFFFF_FFFF));

        // Directed: arm compares, tick through two matches.
        send_request(make_request(ACT_WRITE, 3'(OFF_COMPARE), 32'd2));
        send_request(make_request(ACT_WRITE, 3'(OFF_COMPARE + 1), 32'd3));
        send_request(make_request(ACT_WRITE, 3'(OFF_COMPARE + 2), 32'hFFFF_FFFF));
        send_request(make_request(ACT_WRITE, 3'(OFF_COMPARE + 3), 32'h0000_0000));
        for (int i = 0; i < 4; i++) begin
            send_request(make_request(ACT_TICK, 3'd0, 32'h0000_0000));
        end

        // Directed: status bits above the channel count are ignored, then clear by bit.
        send_request(make_request(ACT_WRITE, OFF_STATUS, 32'hFFFF_FFF0));
        send_request(make_request(ACT_WRITE, OFF_STATUS, 32'h0000_0001));
        send_request(make_request(ACT_READ, OFF_STATUS, 32'h0000_0000));
        send_request(make_request(ACT_WRITE, OFF_STATUS, 32'hFFFF_FFFF));

        // Random traffic, mostly ticks and compare writes aimed just ahead of the count.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            idx  = 3'($urandom_range(0, 7));
            data = $urandom();
            if (pick < 42) begin
                act = ACT_TICK;
            end else if (pick < 66) begin
                act = ACT_READ;
            end else if (pick < 94) begin
                act = ACT_WRITE;
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    idx  = 3'(OFF_COMPARE + $urandom_range(0, CHANNELS - 1));
                    data = sb.tick_count[DATA_W-1:0] + DATA_W'($urandom_range(1, 12));
                end else if (sel < 8) begin
                    idx = OFF_STATUS;
                    if (sel == 5) data = DATA_W'(1) << $urandom_range(0, CHANNELS - 1);
                end
            end else begin
                act = ACT_NONE;
            end
            send_request(make_request(act, idx, data));
        end
        s_valid <= 1'b0;

        // Drain the results still in flight, then allow for the pipeline latency.
        guard = 0;
        while (sb.pending_replies.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (sb.pending_replies.size() != 0) begin
            sb.error_count++;
            $display("%0t: %0d results never arrived", $time, sb.pending_replies.size());
        end

        $display("Sent %0d requests: %0d ticks, %0d reads, %0d writes, %0d no-ops.",
                 sb.ticks + sb.reads + sb.writes + sb.others,
                 sb.ticks, sb.reads, sb.writes, sb.others);
        $display("Checked %0d results; %0d compare channels matched along the way.",
                 sb.checked, sb.match_events);
        if (sb.error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[free_running_timer_with_compares.f]
+incdir+hw/rtl
hw/rtl/frtc_pkg.sv
hw/rtl/frtc_core.sv
hw/rtl/free_running_timer_with_compares.sv
tb/free_running_timer_with_compares_tb.sv
